// File: src/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and constants of the 2x2 box downsampler.
// ----------------------------------------------------------------------------
package rbd_pkg;

	localparam int PIX_W = 8;            // one color channel of a pixel
	localparam int CH_W  = PIX_W + 1;    // sum of two channel values
	localparam int CFG_W = 9;            // page size register as written
	localparam int QUAD_W = CH_W + 1;    // sum of four channel values

	// three channel pair sums, red in the low bits
	typedef struct packed {
		logic [CH_W-1:0] b;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] r;
	} sum3_t;

	// position of the incoming pixel within the page
	typedef struct packed {
		logic active;     // column and row both take part in a block
		logic col_odd;
		logic row_odd;
		logic last;       // last used column of the last used row
	} pos_t;

endpackage

// File: src/rbd_ram.sv
// ----------------------------------------------------------------------------
// rbd_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module rbd_ram #(
	parameter int WIDTH = 27,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds while no read is issued
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/rbd_pos_ctrl.sv
// ----------------------------------------------------------------------------
// rbd_pos_ctrl
// Page size register and raster position counters; decodes where the
// incoming pixel sits within its 2x2 block and gives the line store index.
// ----------------------------------------------------------------------------
module rbd_pos_ctrl #(
	parameter int MAX_PAGE_SIZE = 256,
	localparam int HALF = MAX_PAGE_SIZE / 2,
	localparam int IW = (HALF > 1) ? $clog2(HALF) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      page_size_we,
	input  logic [rbd_pkg::CFG_W-1:0] page_size,
	input  logic                      advance,
	output rbd_pkg::pos_t             pos,
	output logic [IW-1:0]             idx
);

	localparam int PSW = $clog2(MAX_PAGE_SIZE + 1);
	localparam int CW  = $clog2(MAX_PAGE_SIZE);

	logic [PSW-1:0] size_q;
	logic [PSW-1:0] size_d;
	logic [CW-1:0]  col_q;
	logic [CW-1:0]  row_q;
	logic [PSW-1:0] used;
	logic [PSW-1:0] col_x;
	logic [PSW-1:0] row_x;
	logic [PSW-1:0] col_nx;
	logic [PSW-1:0] row_nx;
	logic [CW:0]    col_w;

	always_comb begin
		if (page_size < rbd_pkg::CFG_W'(2)) begin
			size_d = PSW'(2);
		end else if (int'(page_size) > MAX_PAGE_SIZE) begin
			size_d = PSW'(MAX_PAGE_SIZE);
		end else begin
			size_d = PSW'(page_size);
		end
	end

	assign used   = {size_q[PSW-1:1], 1'b0};
	assign col_x  = PSW'(col_q);
	assign row_x  = PSW'(row_q);
	assign col_nx = col_x + PSW'(1);
	assign row_nx = row_x + PSW'(1);
	assign col_w  = {1'b0, col_q};

	assign pos.active  = (col_x < used) && (row_x < used);
	assign pos.col_odd = col_q[0];
	assign pos.row_odd = row_q[0];
	assign pos.last    = (col_x == used - PSW'(1)) && (row_x == used - PSW'(1));
	assign idx         = col_w[IW:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= PSW'(MAX_PAGE_SIZE);
			col_q  <= '0;
			row_q  <= '0;
		end else if (page_size_we) begin
			size_q <= size_d;
			col_q  <= '0;
			row_q  <= '0;
		end else if (advance) begin
			if (col_nx >= size_q) begin
				col_q <= '0;
				if (row_nx >= size_q) begin
					row_q <= '0;
				end else begin
					row_q <= CW'(row_nx);
				end
			end else begin
				col_q <= CW'(col_nx);
			end
		end
	end

endmodule

// File: src/rbd_out_stage.sv
// ----------------------------------------------------------------------------
// rbd_out_stage
// Adds the stored even-row pair sum to the odd-row pair sum, divides by four
// and holds the result pixel in the output register.
// ----------------------------------------------------------------------------
module rbd_out_stage (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s1_valid,
	input  rbd_pkg::sum3_t            below,
	input  rbd_pkg::sum3_t            above,
	input  logic                      last,
	output logic                      s1_adv,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [rbd_pkg::PIX_W-1:0] red_avg,
	output logic [rbd_pkg::PIX_W-1:0] green_avg,
	output logic [rbd_pkg::PIX_W-1:0] blue_avg,
	output logic                      page_done
);

	logic [rbd_pkg::QUAD_W-1:0] sum_r;
	logic [rbd_pkg::QUAD_W-1:0] sum_g;
	logic [rbd_pkg::QUAD_W-1:0] sum_b;
	logic                       out_valid_q;

	assign sum_r = {1'b0, above.r} + {1'b0, below.r};
	assign sum_g = {1'b0, above.g} + {1'b0, below.g};
	assign sum_b = {1'b0, above.b} + {1'b0, below.b};

	assign s1_adv    = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid) begin
			red_avg   <= sum_r[rbd_pkg::QUAD_W-1:2];
			green_avg <= sum_g[rbd_pkg::QUAD_W-1:2];
			blue_avg  <= sum_b[rbd_pkg::QUAD_W-1:2];
			page_done <= last;
		end
	end

endmodule

// File: src/rgb_box_downsample_2x2_core.sv
// ----------------------------------------------------------------------------
// rgb_box_downsample_2x2_core
// 2x2 box filter downsampler for a square RGB page streamed in raster order.
// Horizontal pair sums of even rows go to a line store; odd rows read them
// back and emit one averaged pixel per 2x2 block.
//
//   channel   signals                                   direction
//   in        in_valid in_ready red_in green_in blue_in  pixel in
//   out       out_valid out_ready red_avg green_avg      result out
//             blue_avg page_done
//   config    page_size_we page_size                     register write
//
// one pixel accepted per cycle while the input does not stall; a result passes
// the line store read stage, then the output register
// the line store has one write and one read port; an entry is read one row
// after it was written, so accesses never overlap
// reset sets the page size to MAX_PAGE_SIZE and the position to the top left;
// a page size write restarts the page
// when the output register is full and not taken and the read stage also
// holds a result, the input stalls
// ----------------------------------------------------------------------------
module rgb_box_downsample_2x2_core #(
	parameter int MAX_PAGE_SIZE = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      page_size_we,
	input  logic [rbd_pkg::CFG_W-1:0] page_size,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [rbd_pkg::PIX_W-1:0] red_in,
	input  logic [rbd_pkg::PIX_W-1:0] green_in,
	input  logic [rbd_pkg::PIX_W-1:0] blue_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [rbd_pkg::PIX_W-1:0] red_avg,
	output logic [rbd_pkg::PIX_W-1:0] green_avg,
	output logic [rbd_pkg::PIX_W-1:0] blue_avg,
	output logic                      page_done
);

	localparam int HALF = MAX_PAGE_SIZE / 2;
	localparam int IW = (HALF > 1) ? $clog2(HALF) : 1;
	localparam int SUM_W = $bits(rbd_pkg::sum3_t);

	rbd_pkg::pos_t  pos;
	logic [IW-1:0]  idx;
	logic           accept;
	logic           s1_adv;
	logic           wr_en;
	logic           rd_en;
	rbd_pkg::sum3_t pair_q;
	rbd_pkg::sum3_t pair_d;
	rbd_pkg::sum3_t ps_s1;
	logic           last_s1;
	logic           valid_s1;
	logic [SUM_W-1:0] above_raw;
	rbd_pkg::sum3_t above;

	assign in_ready = !valid_s1 || s1_adv;
	assign accept   = in_valid && in_ready;

	rbd_pos_ctrl #(
		.MAX_PAGE_SIZE(MAX_PAGE_SIZE)
	) u_pos (
		.clk         (clk),
		.arst_n      (arst_n),
		.page_size_we(page_size_we),
		.page_size   (page_size),
		.advance     (accept),
		.pos         (pos),
		.idx         (idx)
	);

	// second pixel of a pair completes the horizontal sum
	always_comb begin
		if (pos.col_odd) begin
			pair_d.r = pair_q.r + rbd_pkg::CH_W'(red_in);
			pair_d.g = pair_q.g + rbd_pkg::CH_W'(green_in);
			pair_d.b = pair_q.b + rbd_pkg::CH_W'(blue_in);
		end else begin
			pair_d.r = rbd_pkg::CH_W'(red_in);
			pair_d.g = rbd_pkg::CH_W'(green_in);
			pair_d.b = rbd_pkg::CH_W'(blue_in);
		end
	end

	assign wr_en = accept && pos.active && pos.col_odd && !pos.row_odd;
	assign rd_en = accept && pos.active && pos.col_odd && pos.row_odd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q <= '0;
		end else if (page_size_we) begin
			pair_q <= '0;
		end else if (accept && pos.active) begin
			pair_q <= pair_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			ps_s1   <= pair_d;
			last_s1 <= pos.last;
		end
	end

	rbd_ram #(
		.WIDTH(SUM_W),
		.DEPTH(HALF)
	) u_line (
		.clk  (clk),
		.we   (wr_en),
		.waddr(idx),
		.wdata(pair_d),
		.re   (rd_en),
		.raddr(idx),
		.rdata(above_raw)
	);

	assign above = rbd_pkg::sum3_t'(above_raw);

	rbd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (valid_s1),
		.below    (ps_s1),
		.above    (above),
		.last     (last_s1),
		.s1_adv   (s1_adv),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.red_avg  (red_avg),
		.green_avg(green_avg),
		.blue_avg (blue_avg),
		.page_done(page_done)
	);

endmodule

// File: dv/rgb_box_downsample_2x2_monitor.sv
// ----------------------------------------------------------------------------
// rgb_box_downsample_2x2_monitor
// Watches the pixel, result and page size channels of the 2x2 box
// downsampler. It keeps its own copy of the page position, the pair sum and
// the line store, works out the averaged pixel due for each 2x2 block the
// input completes, and compares each result transaction against the oldest
// one still owed. It counts mismatches and the results still outstanding.
// ----------------------------------------------------------------------------
module rgb_box_downsample_2x2_monitor #(
	parameter int MAX_PAGE_SIZE = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      page_size_we,
	input  logic [rbd_pkg::CFG_W-1:0] page_size,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [rbd_pkg::PIX_W-1:0] red_in,
	input  logic [rbd_pkg::PIX_W-1:0] green_in,
	input  logic [rbd_pkg::PIX_W-1:0] blue_in,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [rbd_pkg::PIX_W-1:0] red_avg,
	input  logic [rbd_pkg::PIX_W-1:0] green_avg,
	input  logic [rbd_pkg::PIX_W-1:0] blue_avg,
	input  logic                      page_done,
	output int                        errors,
	output int                        outstanding
);

	localparam int HALF_PAGE = MAX_PAGE_SIZE / 2;

	typedef struct packed {
		logic [rbd_pkg::PIX_W-1:0] red;
		logic [rbd_pkg::PIX_W-1:0] green;
		logic [rbd_pkg::PIX_W-1:0] blue;
		logic                      done;
	} avg_pixel_t;

	logic [rbd_pkg::CFG_W-1:0] page_cfg;
	logic [rbd_pkg::CFG_W-1:0] col;
	logic [rbd_pkg::CFG_W-1:0] row;
	rbd_pkg::sum3_t            pair_acc;
	rbd_pkg::sum3_t            even_row_sums [HALF_PAGE];
	avg_pixel_t                owed_avgs [$];
	int                        n_results;

	initial errors = 0;

	task automatic report(input string msg);
		$display("mismatch at result %0d: %s", n_results, msg);
		errors++;
	endtask

	task automatic downsample_pixel(input logic [rbd_pkg::PIX_W-1:0] r, g, b);
		logic [rbd_pkg::CFG_W-1:0] used;
		rbd_pkg::sum3_t            pair;
		rbd_pkg::sum3_t            above;
		avg_pixel_t                avg;
		int                        slot;
		used = page_cfg & ~rbd_pkg::CFG_W'(1);
		slot = (col >> 1) % HALF_PAGE;
		if (col < used && row < used) begin
			if (!col[0]) begin
				pair_acc = '{b: rbd_pkg::CH_W'(b), g: rbd_pkg::CH_W'(g),
					r: rbd_pkg::CH_W'(r)};
			end else begin
				pair.r = pair_acc.r + rbd_pkg::CH_W'(r);
				pair.g = pair_acc.g + rbd_pkg::CH_W'(g);
				pair.b = pair_acc.b + rbd_pkg::CH_W'(b);
				pair_acc = pair;
				if (!row[0]) begin
					even_row_sums[slot] = pair;
				end else begin
					above = even_row_sums[slot];
					avg.red   = rbd_pkg::PIX_W'((rbd_pkg::QUAD_W'(above.r) +
						rbd_pkg::QUAD_W'(pair.r)) >> 2);
					avg.green = rbd_pkg::PIX_W'((rbd_pkg::QUAD_W'(above.g) +
						rbd_pkg::QUAD_W'(pair.g)) >> 2);
					avg.blue  = rbd_pkg::PIX_W'((rbd_pkg::QUAD_W'(above.b) +
						rbd_pkg::QUAD_W'(pair.b)) >> 2);
					avg.done  = (col == used - rbd_pkg::CFG_W'(1)) &&
						(row == used - rbd_pkg::CFG_W'(1));
					owed_avgs.push_back(avg);
				end
			end
		end
		// advance in raster order, wrapping to a new page
		if (col + rbd_pkg::CFG_W'(1) >= page_cfg) begin
			col = '0;
			row = (row + rbd_pkg::CFG_W'(1) >= page_cfg) ? '0 : row + rbd_pkg::CFG_W'(1);
		end else begin
			col = col + rbd_pkg::CFG_W'(1);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		avg_pixel_t want;
		if (!arst_n) begin
			page_cfg = rbd_pkg::CFG_W'(MAX_PAGE_SIZE);
			col = '0;
			row = '0;
			pair_acc = '0;
			owed_avgs.delete();
			n_results = 0;
			outstanding <= 0;
		end else begin
			if (page_size_we) begin
				if (page_size < 2)
					page_cfg = rbd_pkg::CFG_W'(2);
				else if (page_size > MAX_PAGE_SIZE)
					page_cfg = rbd_pkg::CFG_W'(MAX_PAGE_SIZE);
				else
					page_cfg = page_size;
				col = '0;
				row = '0;
				pair_acc = '0;
			end else if (in_valid && in_ready) begin
				downsample_pixel(red_in, green_in, blue_in);
			end
			if (out_valid && out_ready) begin
				if (owed_avgs.size() == 0) begin
					report("result with none owed");
				end else begin
					want = owed_avgs.pop_front();
					if (red_avg !== want.red)
						report($sformatf("red_avg %0d, want %0d", red_avg, want.red));
					if (green_avg !== want.green)
						report($sformatf("green_avg %0d, want %0d", green_avg, want.green));
					if (blue_avg !== want.blue)
						report($sformatf("blue_avg %0d, want %0d", blue_avg, want.blue));
					if (page_done !== want.done)
						report($sformatf("page_done %0b, want %0b", page_done, want.done));
				end
				n_results++;
			end
			outstanding <= owed_avgs.size();
		end
	end

endmodule

// File: dv/rgb_box_downsample_2x2_core_test.sv
// ----------------------------------------------------------------------------
// rgb_box_downsample_2x2_core_test
// Streams pixels into the 2x2 box downsampler over a range of page sizes,
// saturated, odd and even ones among them, with random gaps on both sides.
// A short directed run covers channel extremes and rounding, then random
// pages follow. The monitor beside the block checks every result.
// ----------------------------------------------------------------------------
module rgb_box_downsample_2x2_core_test;

	localparam int NUM_PHASES = 11;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT = 20000;
	localparam int FIRST_SWAP = 633;
	localparam int SECOND_SWAP = 1266;

	// page size as written, and how many pixels to stream under it
	localparam int PHASE_SIZE [NUM_PHASES] = '{4, 6, 257, 5, 8, 2, 511, 16, 7, 1, 256};
	localparam int PHASE_ITEMS [NUM_PHASES] = '{64, 108, 512, 100, 192, 60, 300, 256, 147,
		40, 120};

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      page_size_we = 1'b0;
	logic [rbd_pkg::CFG_W-1:0] page_size = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [rbd_pkg::PIX_W-1:0] red_in = '0;
	logic [rbd_pkg::PIX_W-1:0] green_in = '0;
	logic [rbd_pkg::PIX_W-1:0] blue_in = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [rbd_pkg::PIX_W-1:0] red_avg;
	logic [rbd_pkg::PIX_W-1:0] green_avg;
	logic [rbd_pkg::PIX_W-1:0] blue_avg;
	logic                      page_done;
	int                        errors;
	int                        outstanding;
	int                        send_idle = 20;
	int                        recv_idle = 60;

	rgb_box_downsample_2x2_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.page_size_we (page_size_we),
		.page_size    (page_size),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.red_in       (red_in),
		.green_in     (green_in),
		.blue_in      (blue_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.red_avg      (red_avg),
		.green_avg    (green_avg),
		.blue_avg     (blue_avg),
		.page_done    (page_done)
	);

	rgb_box_downsample_2x2_monitor mon (
		.clk          (clk),
		.arst_n       (arst_n),
		.page_size_we (page_size_we),
		.page_size    (page_size),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.red_in       (red_in),
		.green_in     (green_in),
		.blue_in      (blue_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.red_avg      (red_avg),
		.green_avg    (green_avg),
		.blue_avg     (blue_avg),
		.page_done    (page_done),
		.errors       (errors),
		.outstanding  (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_idle);
	end

	function automatic logic [rbd_pkg::PIX_W-1:0] rand_channel();
		int pick;
		pick = $urandom_range(7);
		if (pick == 0)
			return '0;
		else if (pick == 1)
			return '1;
		return rbd_pkg::PIX_W'($urandom_range(255));
	endfunction

	task automatic push_pixel(input logic [rbd_pkg::PIX_W-1:0] r, g, b);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_page_size(input logic [rbd_pkg::CFG_W-1:0] value);
		drain_results();
		// a pixel that makes no result may still be in the pipe
		repeat (SETTLE_CYCLES) @(posedge clk);
		page_size_we <= 1'b1;
		page_size <= value;
		@(posedge clk);
		page_size_we <= 1'b0;
	endtask

	initial begin
		int i;
		int k;
		int sent;
		int hold_at;
		int waited;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero saturates to the smallest page, one block per page
		write_page_size(rbd_pkg::CFG_W'(0));
		repeat (4) push_pixel(8'd255, 8'd255, 8'd255);
		repeat (4) push_pixel(8'd0, 8'd0, 8'd0);
		// truncation: sums just short of a multiple of four
		push_pixel(8'd1, 8'd255, 8'd2);
		push_pixel(8'd1, 8'd255, 8'd1);
		push_pixel(8'd1, 8'd255, 8'd0);
		push_pixel(8'd0, 8'd254, 8'd0);
		write_page_size(rbd_pkg::CFG_W'(1));
		push_pixel(8'hAA, 8'h55, 8'h0F);
		push_pixel(8'h55, 8'hAA, 8'hF0);
		push_pixel(8'hFF, 8'h00, 8'h80);
		push_pixel(8'h01, 8'hFE, 8'h7F);
		// odd page: last column and last row are dropped
		write_page_size(rbd_pkg::CFG_W'(3));
		for (i = 0; i < 9; i++)
			push_pixel(rbd_pkg::PIX_W'(i * 31), rbd_pkg::PIX_W'(255 - i * 17),
				rbd_pkg::PIX_W'(i * i * 3));

		sent = 0;
		for (k = 0; k < NUM_PHASES; k++) begin
			write_page_size(rbd_pkg::CFG_W'(PHASE_SIZE[k]));
			hold_at = $urandom_range(PHASE_ITEMS[k] - 1);
			for (i = 0; i < PHASE_ITEMS[k]; i++) begin
				send_idle = (sent < FIRST_SWAP) ? 20 : (sent < SECOND_SWAP) ? 60 : 0;
				recv_idle <= (sent < FIRST_SWAP) ? 60 : (sent < SECOND_SWAP) ? 20 : 0;
				if (i == hold_at)
					drain_results();
				push_pixel(rand_channel(), rand_channel(), rand_channel());
				sent++;
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		waited = 0;
		while (outstanding != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (outstanding != 0) begin
			$display("[rgb_box_downsample_2x2_core] ERROR");
			$finish;
		end else begin
			repeat (SETTLE_CYCLES) @(posedge clk);
			if (errors == 0)
				$display("[rgb_box_downsample_2x2_core] OK");
			else
				$display("[rgb_box_downsample_2x2_core] ERROR");
			$finish;
		end
	end

	initial begin
		#2000000;
		$display("[rgb_box_downsample_2x2_core] ERROR");
		$finish;
	end

endmodule

// File: files.f
src/rbd_pkg.sv
src/rbd_ram.sv
src/rbd_pos_ctrl.sv
src/rbd_out_stage.sv
src/rgb_box_downsample_2x2_core.sv
dv/rgb_box_downsample_2x2_monitor.sv
dv/rgb_box_downsample_2x2_core_test.sv
